// ===== src/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and helpers of the fade dimmer
// word formats, command and register codes, ramp arithmetic
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int CHANNELS = 4;

   localparam logic [6:0]  LEVEL_FULL  = 7'd100;
   localparam logic [7:0]  COLOUR_FULL = 8'd255;

   // floor(x / 100) == (x * 5243) >> 19 for every x below 25600
   localparam int          SCALE_W     = 20;
   localparam logic [19:0] LEVEL_RECIP = 20'd5243;
   localparam int          RECIP_SHIFT = 19;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_LEVEL  = 2'd1,
      MODE_SWITCH = 2'd2,
      MODE_COLOUR = 2'd3
   } mfd_mode_type;

   typedef enum logic [1:0] {
      CSR_STEP_SIZE = 2'd0,
      CSR_INTERVAL  = 2'd1,
      CSR_CHANNELS  = 2'd2
   } mfd_csr_type;

   typedef struct packed {
      mfd_mode_type mode;
      logic [6:0]   level_target;
      logic         switch_on;
      logic [7:0]   colour_0;
      logic [7:0]   colour_1;
      logic [7:0]   colour_2;
      logic [7:0]   colour_3;
   } mfd_req_type;

   typedef struct packed {
      logic [7:0] duty_0;
      logic [7:0] duty_1;
      logic [7:0] duty_2;
      logic [7:0] duty_3;
      logic [6:0] present_level;
      logic       ramping;
   } mfd_rsp_type;

   // state after one update, handed to the duty stage
   typedef struct packed {
      logic [SCALE_W-1:0]         level_scale;
      logic [CHANNELS-1:0][7:0]   colour;
      logic [6:0]                 present_level;
      logic                       ramping;
   } mfd_snap_type;

   function automatic logic [2:0] active_channels(input logic [2:0] n);
      logic [2:0] r;
      if (n == 3'd0)      r = 3'd1;
      else if (n > 3'd4)  r = 3'd4;
      else                r = n;
      return r;
   endfunction

   function automatic logic [7:0] move_toward(input logic [7:0] now,
                                              input logic [7:0] goal,
                                              input logic [6:0] step);
      logic [7:0] diff;
      logic [7:0] r;
      r = now;
      if (now < goal) begin
         diff = goal - now;
         r = (diff <= {1'b0, step}) ? goal : now + {1'b0, step};
      end else if (now > goal) begin
         diff = now - goal;
         r = (diff <= {1'b0, step}) ? goal : now - {1'b0, step};
      end
      return r;
   endfunction

   // channels that are in use, multi-channel, and off their goal
   function automatic logic [CHANNELS-1:0] colour_diff(
      input logic [CHANNELS-1:0][7:0] now,
      input logic [CHANNELS-1:0][7:0] goal,
      input logic [2:0]               n);
      logic [CHANNELS-1:0] d;
      for (int i = 0; i < CHANNELS; i++) begin
         d[i] = (3'(i) < n) && (n != 3'd1) && (now[i] != goal[i]);
      end
      return d;
   endfunction

endpackage

// ===== src/mfd_state.sv =====
// ----------------------------------------------------------------------------
// mfd_state: fade state and its one-word update
// level, colours, power and interval timer; applies one word per go
// ----------------------------------------------------------------------------
module mfd_state (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  mfd_pkg::mfd_req_type word,
   input  logic [6:0]           step_size,
   input  logic [15:0]          interval_ticks,
   input  logic [2:0]           channel_count,
   output mfd_pkg::mfd_snap_type snap
);
   import mfd_pkg::*;

   logic [6:0]                level_now_ff, level_now_in;
   logic [6:0]                level_goal_ff, level_goal_in;
   logic [6:0]                remembered_ff, remembered_in;
   logic                      powered_ff, powered_in;
   logic [CHANNELS-1:0][7:0]  colour_now_ff, colour_now_in;
   logic [CHANNELS-1:0][7:0]  colour_goal_ff, colour_goal_in;
   logic [15:0]               tick_count_ff, tick_count_in;

   logic [2:0]                chan_n;
   logic [6:0]                step_eff;
   logic [15:0]               interval_eff;
   logic [6:0]                target_sat;
   logic [CHANNELS-1:0]       diff_old, diff_new;
   logic                      ramp_old;
   logic                      found;

   assign chan_n       = active_channels(channel_count);
   assign step_eff     = (step_size == 7'd0) ? 7'd1 : step_size;
   assign interval_eff = (interval_ticks == 16'd0) ? 16'd1 : interval_ticks;
   assign target_sat   = (word.level_target > LEVEL_FULL) ? LEVEL_FULL : word.level_target;
   assign diff_old     = colour_diff(colour_now_ff, colour_goal_ff, chan_n);
   assign ramp_old     = (level_now_ff != level_goal_ff) || (|diff_old);

   always_comb begin
      level_now_in   = level_now_ff;
      level_goal_in  = level_goal_ff;
      remembered_in  = remembered_ff;
      powered_in     = powered_ff;
      colour_now_in  = colour_now_ff;
      colour_goal_in = colour_goal_ff;
      tick_count_in  = tick_count_ff;
      found          = 1'b0;
      unique case (word.mode)
         MODE_TICK: begin
            if (!ramp_old) begin
               tick_count_in = 16'd0;
            end else if ({1'b0, tick_count_ff} + 17'd1 >= {1'b0, interval_eff}) begin
               tick_count_in = 16'd0;
               if (level_now_ff != level_goal_ff) begin
                  level_now_in = 7'(move_toward({1'b0, level_now_ff},
                                                {1'b0, level_goal_ff}, step_eff));
               end else begin
                  // lowest channel off its goal takes the step
                  for (int i = 0; i < CHANNELS; i++) begin
                     if (!found && diff_old[i]) begin
                        colour_now_in[i] = move_toward(colour_now_ff[i],
                                                       colour_goal_ff[i], step_eff);
                        found = 1'b1;
                     end
                  end
               end
            end else begin
               tick_count_in = tick_count_ff + 16'd1;
            end
         end
         MODE_LEVEL: begin
            if (powered_ff) level_goal_in = target_sat;
            else            remembered_in = target_sat;
         end
         MODE_SWITCH: begin
            if (!word.switch_on && powered_ff) begin
               remembered_in = level_goal_ff;
               level_goal_in = 7'd0;
               powered_in    = 1'b0;
            end else if (word.switch_on && !powered_ff) begin
               powered_in    = 1'b1;
               level_now_in  = 7'd0;
               level_goal_in = remembered_ff;
            end
         end
         MODE_COLOUR: begin
            colour_goal_in = {word.colour_3, word.colour_2, word.colour_1, word.colour_0};
         end
      endcase
   end

   assign diff_new = colour_diff(colour_now_in, colour_goal_in, chan_n);

   always_comb begin
      snap.level_scale   = SCALE_W'(level_now_in) * LEVEL_RECIP;
      snap.present_level = level_now_in;
      snap.ramping       = (level_now_in != level_goal_in) || (|diff_new);
      for (int i = 0; i < CHANNELS; i++) begin
         if (3'(i) >= chan_n)       snap.colour[i] = 8'd0;
         else if (chan_n == 3'd1)   snap.colour[i] = COLOUR_FULL;
         else                       snap.colour[i] = colour_now_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_now_ff   <= '0;
         level_goal_ff  <= '0;
         remembered_ff  <= '0;
         powered_ff     <= 1'b0;
         colour_now_ff  <= '0;
         colour_goal_ff <= '0;
         tick_count_ff  <= '0;
      end else if (go) begin
         level_now_ff   <= level_now_in;
         level_goal_ff  <= level_goal_in;
         remembered_ff  <= remembered_in;
         powered_ff     <= powered_in;
         colour_now_ff  <= colour_now_in;
         colour_goal_ff <= colour_goal_in;
         tick_count_ff  <= tick_count_in;
      end
   end

endmodule

// ===== src/mfd_duty.sv =====
// ----------------------------------------------------------------------------
// mfd_duty: duty scaling and result register
// duty = floor(level * colour / 100) through a reciprocal multiply
// ----------------------------------------------------------------------------
module mfd_duty (
   input  logic                  clock,
   input  logic                  load,
   input  mfd_pkg::mfd_snap_type snap,
   output mfd_pkg::mfd_rsp_type  word_ff
);
   import mfd_pkg::*;

   localparam int PROD_W = SCALE_W + 8;

   logic [CHANNELS-1:0][PROD_W-1:0] prod;
   logic [CHANNELS-1:0][7:0]        duty;
   mfd_rsp_type                     word_in;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         prod[i] = PROD_W'(snap.level_scale) * PROD_W'(snap.colour[i]);
         duty[i] = prod[i][RECIP_SHIFT +: 8];
      end
      word_in.duty_0        = duty[0];
      word_in.duty_1        = duty[1];
      word_in.duty_2        = duty[2];
      word_in.duty_3        = duty[3];
      word_in.present_level = snap.present_level;
      word_in.ramping       = snap.ramping;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== src/multichannel_fade_dimmer_unit.sv =====
// a word accepted into the input register reaches the consumer through the snapshot
// register and then the result register
// throughput: one word per cycle, sustained with rsp_ready held high
// path: input register, state update, scaled-level register, duty multiply, result register
// reset: synchronous, active high; light off, all levels and colours zero,
// step_size 1, interval_ticks 10, channel_count 4
// ----------------------------------------------------------------------------
// multichannel_fade_dimmer_unit: four-channel fade dimmer
// ticks ramp the level toward its goal, then the colours one channel at a time;
// commands set the level goal, switch on or off, or load colour goals
// ----------------------------------------------------------------------------
module multichannel_fade_dimmer_unit (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mfd_pkg::mfd_req_type  req_word,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mfd_pkg::mfd_rsp_type  rsp_word,
   // register writes
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);
   import mfd_pkg::*;

   // configuration registers
   logic [6:0]   step_size_ff;
   logic [15:0]  interval_ff;
   logic [2:0]   channels_ff;

   // stage 0: input word register
   logic         s0_valid_ff, s0_valid_in;
   mfd_req_type  s0_word_ff, s0_word_in;
   // stage 1: updated state snapshot
   logic         s1_valid_ff, s1_valid_in;
   mfd_snap_type s1_snap_ff;
   mfd_snap_type snap_next;
   // stage 2: result register
   logic         rsp_valid_ff, rsp_valid_in;

   logic         req_take;
   logic         out_free;
   logic         s1_go, s1_free;
   logic         s0_go;

   // each stage moves on when the one after it is empty or emptying
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign s1_free   = !s1_valid_ff || s1_go;
   assign s0_go     = s0_valid_ff && s1_free;
   assign req_ready = !s0_valid_ff || s0_go;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= 7'd1;
         interval_ff  <= 16'd10;
         channels_ff  <= 3'd4;
      end else if (csr_write_en) begin
         unique case (mfd_csr_type'(csr_index))
            CSR_STEP_SIZE: step_size_ff <= csr_data[6:0];
            CSR_INTERVAL:  interval_ff  <= csr_data;
            CSR_CHANNELS:  channels_ff  <= csr_data[2:0];
            default: ;    // unused index, write dropped
         endcase
      end
   end

   always_comb begin
      s0_word_in   = req_take ? req_word : s0_word_ff;
      s0_valid_in  = req_take ? 1'b1 : (s0_go ? 1'b0 : s0_valid_ff);
      s1_valid_in  = s0_go    ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_go    ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_word_ff <= s0_word_in;
      if (s0_go) begin
         s1_snap_ff <= snap_next;
      end
   end

   // state is committed as the word leaves stage 0
   mfd_state u_state (
      .clock          (clock),
      .reset          (reset),
      .go             (s0_go),
      .word           (s0_word_ff),
      .step_size      (step_size_ff),
      .interval_ticks (interval_ff),
      .channel_count  (channels_ff),
      .snap           (snap_next)
   );

   // duty multiply into the result register
   mfd_duty u_duty (
      .clock   (clock),
      .load    (s1_go),
      .snap    (s1_snap_ff),
      .word_ff (rsp_word)
   );

   // the level never leaves its percent range
   a_level_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_word.present_level <= LEVEL_FULL)
      else $error("present level above full scale");

   // a single channel setup drives only channel 0
   a_single_channel : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && active_channels(channels_ff) == 3'd1 |->
         rsp_word.duty_1 == 8'd0 && rsp_word.duty_2 == 8'd0 && rsp_word.duty_3 == 8'd0)
      else $error("unused channel shows a duty");

   // a held input word is neither lost nor overwritten
   a_s0_hold : assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !s0_go |=> s0_valid_ff && $stable(s0_word_ff))
      else $error("stalled input word changed");

   // a result waiting for the consumer stays put
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && !$past(s1_go))
      else $error("result register overwritten while stalled");

endmodule

// ===== tb/multichannel_fade_dimmer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_fade_dimmer_unit_tb: self-checking bench for the fade dimmer
// drives tick and command words through the request channel, predicts every
// result word from a bit-accurate model of the ramp, and compares field by field
// ----------------------------------------------------------------------------
module multichannel_fade_dimmer_unit_tb;
   import mfd_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   // block inputs, all known from time zero
   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   mfd_req_type req_word     = '0;
   logic        rsp_ready    = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index    = '0;
   logic [15:0] csr_data     = '0;

   // block outputs
   logic        req_ready;
   logic        rsp_valid;
   mfd_rsp_type rsp_word;

   multichannel_fade_dimmer_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // shadow of the dimmer state, matching the reset values of the block
   logic [6:0]  lvl_now      = '0;
   logic [6:0]  lvl_goal     = '0;
   logic [6:0]  lvl_saved    = '0;
   logic        lamp_on      = 1'b0;
   logic [7:0]  hue_now  [4] = '{default: '0};
   logic [7:0]  hue_goal [4] = '{default: '0};
   logic [15:0] tick_cnt     = '0;

   // shadow of the registers
   logic [6:0]  cfg_step     = 7'd1;
   logic [15:0] cfg_interval = 16'd10;
   logic [2:0]  cfg_channels = 3'd4;

   // result words still owed by the block, oldest first
   mfd_rsp_type predicted_outputs [$];
   mfd_rsp_type want_word;

   int fail_count    = 0;
   int checked_count = 0;
   int cycle_count   = 0;
   int tick_total    = 0;
   int level_total   = 0;
   int switch_total  = 0;
   int colour_total  = 0;
   int step_total    = 0;
   int setting_total = 0;

   // idling controls
   bit sender_gaps = 1'b1;
   bit stalls_on   = 1'b1;
   int burst_left  = 0;
   int ready_hold  = 0;
   bit ready_level = 1'b1;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // ramp model
   // -------------------------------------------------------------------------

   // out-of-range channel counts fold into 1..4
   function automatic int used_channels();
      if (cfg_channels == 3'd0) return 1;
      if (cfg_channels > 3'd4) return 4;
      return int'(cfg_channels);
   endfunction

   // one clamped move toward the goal, never past it
   function automatic int ramp_toward(input int now, input int goal, input int stride);
      if (now < goal) return (goal - now <= stride) ? goal : now + stride;
      if (now > goal) return (now - goal <= stride) ? goal : now - stride;
      return now;
   endfunction

   // level off its goal, or an active colour off its goal (not in single-channel)
   function automatic bit fading();
      int n;
      bit busy;
      n = used_channels();
      busy = (lvl_now != lvl_goal);
      if (n > 1) begin
         for (int i = 0; i < n; i++) begin
            if (hue_now[i] != hue_goal[i]) busy = 1'b1;
         end
      end
      return busy;
   endfunction

   // level first; once it has arrived, the lowest channel still off its goal
   task automatic take_ramp_step();
      int n;
      int stride;
      bit moved;
      n = used_channels();
      stride = (cfg_step == 7'd0) ? 1 : int'(cfg_step);
      moved = 1'b0;
      if (lvl_now != lvl_goal) begin
         lvl_now = 7'(ramp_toward(lvl_now, lvl_goal, stride));
      end else if (n > 1) begin
         for (int i = 0; i < n; i++) begin
            if (!moved && hue_now[i] != hue_goal[i]) begin
               hue_now[i] = 8'(ramp_toward(hue_now[i], hue_goal[i], stride));
               moved = 1'b1;
            end
         end
      end
   endtask

   // apply one accepted word to the shadow state and queue the result it owes
   task automatic update_lamp(input mfd_req_type w);
      mfd_rsp_type r;
      int goal;
      int period;
      int n;
      int shade;
      logic [7:0] duty [4];
      goal = (w.level_target > LEVEL_FULL) ? int'(LEVEL_FULL) : int'(w.level_target);
      case (w.mode)
         MODE_TICK: begin
            tick_total++;
            // timer idles at zero while nothing ramps
            if (!fading()) begin
               tick_cnt = '0;
            end else begin
               period = (cfg_interval == 16'd0) ? 1 : int'(cfg_interval);
               if (int'(tick_cnt) + 1 >= period) begin
                  tick_cnt = '0;
                  take_ramp_step();
                  step_total++;
               end else begin
                  tick_cnt = tick_cnt + 16'd1;
               end
            end
         end
         MODE_LEVEL: begin
            level_total++;
            // while dark the target is only remembered
            if (lamp_on) lvl_goal = 7'(goal);
            else lvl_saved = 7'(goal);
         end
         MODE_SWITCH: begin
            switch_total++;
            if (!w.switch_on && lamp_on) begin
               lvl_saved = lvl_goal;
               lvl_goal = '0;
               lamp_on = 1'b0;
            end else if (w.switch_on && !lamp_on) begin
               lamp_on = 1'b1;
               lvl_now = '0;
               lvl_goal = lvl_saved;
            end
         end
         MODE_COLOUR: begin
            colour_total++;
            hue_goal[0] = w.colour_0;
            hue_goal[1] = w.colour_1;
            hue_goal[2] = w.colour_2;
            hue_goal[3] = w.colour_3;
         end
         default: ;
      endcase

      n = used_channels();
      for (int i = 0; i < 4; i++) begin
         // single channel shows full white
         shade = (n == 1) ? int'(COLOUR_FULL) : int'(hue_now[i]);
         duty[i] = (i < n) ? 8'((int'(lvl_now) * shade) / int'(LEVEL_FULL)) : 8'd0;
      end
      r.duty_0 = duty[0];
      r.duty_1 = duty[1];
      r.duty_2 = duty[2];
      r.duty_3 = duty[3];
      r.present_level = lvl_now;
      r.ramping = fading();
      predicted_outputs.push_back(r);
   endtask

   // -------------------------------------------------------------------------
   // checking
   // -------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // results are checked before the same edge's request is predicted,
   // so ordering inside the step never matters
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want_word = predicted_outputs.pop_front();
               compare_field("duty_0", want_word.duty_0, rsp_word.duty_0);
               compare_field("duty_1", want_word.duty_1, rsp_word.duty_1);
               compare_field("duty_2", want_word.duty_2, rsp_word.duty_2);
               compare_field("duty_3", want_word.duty_3, rsp_word.duty_3);
               compare_field("present_level", want_word.present_level,
                             rsp_word.present_level);
               compare_field("ramping", want_word.ramping, rsp_word.ramping);
               checked_count++;
            end
         end
         if (req_valid && req_ready) update_lamp(req_word);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("multichannel_fade_dimmer_unit test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // result side: alternating open and stall runs, or always open when quiet
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         ready_level = stalls_on ? !ready_level : 1'b1;
         ready_hold = ready_level ? $urandom_range(1, 12) : $urandom_range(1, 6);
      end
      ready_hold--;
      rsp_ready <= ready_level;
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // called and returns at a falling edge; valid stays high across a burst
   task automatic send_word(input mfd_req_type w);
      int gap;
      if (burst_left == 0) begin
         gap = sender_gaps ? $urandom_range(0, 5) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      @(negedge clock);
   endtask

   // hold the sender until every owed result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (predicted_outputs.size() != 0);
   endtask

   // every result carries one word, so an empty queue means the block is idle
   task automatic apply_settings(input int step, input int interval, input int chans);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_index <= CSR_STEP_SIZE;
      csr_data <= 16'(step);
      @(negedge clock);
      csr_index <= CSR_INTERVAL;
      csr_data <= 16'(interval);
      @(negedge clock);
      csr_index <= CSR_CHANNELS;
      csr_data <= 16'(chans);
      @(negedge clock);
      csr_write_en <= 1'b0;
      cfg_step = 7'(step);
      cfg_interval = 16'(interval);
      cfg_channels = 3'(chans);
      setting_total++;
   endtask

   // word of the given mode with every other field random
   function automatic mfd_req_type random_word(input mfd_mode_type m);
      mfd_req_type w;
      w.mode = m;
      w.level_target = 7'($urandom_range(0, 127));
      w.switch_on = 1'($urandom_range(0, 1));
      w.colour_0 = 8'($urandom);
      w.colour_1 = 8'($urandom);
      w.colour_2 = 8'($urandom);
      w.colour_3 = 8'($urandom);
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------

   // reset registers: dark lamp, remembered target, redundant switches, first step
   task automatic test_power_sequence();
      mfd_req_type w;
      send_word(random_word(MODE_TICK));          // idle tick keeps timer at zero
      w = random_word(MODE_LEVEL);
      w.level_target = 7'd127;                    // saturates, stored while off
      send_word(w);
      w = random_word(MODE_SWITCH);
      w.switch_on = 1'b0;                         // already off
      send_word(w);
      w.switch_on = 1'b1;                         // fades from zero
      send_word(w);
      send_word(w);                               // already on
      w = random_word(MODE_COLOUR);
      w.colour_0 = 8'd255;
      w.colour_1 = 8'd0;
      w.colour_2 = 8'd128;
      w.colour_3 = 8'd1;
      send_word(w);
      // first step lands a full interval after the change
      repeat (10) send_word(random_word(MODE_TICK));
   endtask

   // step of full scale, shortest interval, single channel fixed at full colour
   task automatic test_single_channel_extremes();
      mfd_req_type w;
      apply_settings(100, 1, 1);
      send_word(random_word(MODE_TICK));          // clamps straight to the goal
      w = random_word(MODE_LEVEL);
      w.level_target = 7'd0;
      send_word(w);
      send_word(random_word(MODE_TICK));
      w = random_word(MODE_SWITCH);
      w.switch_on = 1'b0;
      send_word(w);
      w = random_word(MODE_LEVEL);
      w.level_target = 7'd101;
      send_word(w);
      w = random_word(MODE_SWITCH);
      w.switch_on = 1'b1;
      send_word(w);
      send_word(random_word(MODE_TICK));          // full level, full white
      send_word(random_word(MODE_COLOUR));        // goals stored but never shown
   endtask

   // phases of random traffic under a sweep of register settings
   task automatic test_random_phases();
      int step_plan  [8] = '{1, 0, 127, 5, 100, 3, 1, 0};
      int span_plan  [8] = '{1, 0, 65535, 2, 1, 1, 3, 0};
      int chan_plan  [8] = '{4, 0, 7, 2, 3, 5, 4, 0};
      int phase_items;
      int pick;
      mfd_mode_type m;
      mfd_req_type w;
      for (int p = 0; p < 8; p++) begin
         if (p == 7) begin
            step_plan[p] = $urandom_range(0, 127);
            span_plan[p] = $urandom_range(0, 4);
            chan_plan[p] = $urandom_range(0, 7);
         end
         apply_settings(step_plan[p], span_plan[p], chan_plan[p]);
         // first phase runs with no idling on either side
         sender_gaps = (p != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
         // the long interval never steps, so keep that phase short
         phase_items = (span_plan[p] == 65535) ? 60 : 163;
         for (int k = 0; k < phase_items; k++) begin
            // mostly ticks so ramps run to completion between commands
            pick = $urandom_range(0, 99);
            if (pick < 72) m = MODE_TICK;
            else if (pick < 82) m = MODE_LEVEL;
            else if (pick < 90) m = MODE_SWITCH;
            else m = MODE_COLOUR;
            w = random_word(m);
            // keep the lamp mostly lit so level and colour ramps show
            if (m == MODE_SWITCH) w.switch_on = ($urandom_range(0, 9) < 7);
            send_word(w);
            if (p == 3 && k == phase_items / 2) wait_drained();
         end
      end
      sender_gaps = 1'b1;
      stalls_on = 1'b1;
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_power_sequence();
      test_single_channel_extremes();
      test_random_phases();
      wait_drained();
      repeat (10) @(negedge clock);
      $display("ran %0d ticks and %0d level, %0d switch, %0d colour commands",
               tick_total, level_total, switch_total, colour_total);
      $display("%0d ramp steps over %0d register settings, %0d results compared",
               step_total, setting_total, checked_count);
      if (fail_count == 0) begin
         $display("multichannel_fade_dimmer_unit test passed");
      end else begin
         $display("multichannel_fade_dimmer_unit test failed");
      end
      $finish;
   end

endmodule
